[rtl/tse_pkg.sv]
// tse_pkg: shared widths, reset values and microcode types for the taylor sine evaluator
// holds the control store (microprogram) read by tse_seq
// no dependencies
`default_nettype none

package tse_pkg;

    // field and datapath widths
    localparam int IDX_W      = 16;
    localparam int DIV_W      = 16;
    localparam int TC_W       = 5;
    localparam int SINE_W     = 32;
    localparam int OUT_FRAC   = 24;
    localparam int PHASE_W    = 40;
    localparam int WIDE_W     = 48;
    localparam int QUOT_W     = 32;
    localparam int PROD_W     = 2 * WIDE_W;
    localparam int DIGIT_W    = 16;
    localparam int MUL_CYCLES = WIDE_W / DIGIT_W;
    localparam int DIV_RADIX  = 4;
    localparam int DIV_CYCLES = WIDE_W / DIV_RADIX;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = 4;

    // defaults for top level parameters
    localparam int MAX_TERMS_DEF = 16;
    localparam int FRAC_BITS_DEF = 24;

    // 2*pi in unsigned Q3.29
    localparam logic [QUOT_W-1:0] TWO_PI_Q29 = 32'hC90F_DAA2;

    localparam logic [TC_W-1:0]  TERM_COUNT_RST = 5'd8;
    localparam logic [DIV_W-1:0] PERIOD_DIV_RST = 16'd64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_DIVISOR = 2'd1;

    typedef enum logic [3:0] {
        UOP_WAIT_IN,
        UOP_CHECK,
        UOP_DIV_PHASE,
        UOP_MUL_PHASE,
        UOP_MUL_SQ,
        UOP_LOOP_TEST,
        UOP_FIRST_TEST,
        UOP_MUL_TERM,
        UOP_DIV_TERM,
        UOP_ACCUM,
        UOP_EMIT,
        UOP_EMIT_OOR
    } t_uop;

    typedef enum logic [1:0] {
        U_NONE,
        U_MUL,
        U_DIV
    } t_unit;

    typedef enum logic [1:0] {
        W_NONE,
        W_INPUT,
        W_UNIT,
        W_OUTPUT
    } t_wait;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_IF_OOR,
        C_IF_LOOP_END,
        C_IF_FIRST
    } t_cond;

    typedef struct packed {
        t_uop              op;
        t_unit             unit;
        t_wait             wait_on;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        t_uop op;
        logic advance;
        logic mul_go;
        logic div_go;
    } t_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic accept;
        logic unit_done;
        logic out_free;
        logic oor;
        logic loop_end;
        logic first;
    } t_flags;

    localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK     = 4'd1;
    localparam logic [STEP_W-1:0] STEP_DIV_PHASE = 4'd2;
    localparam logic [STEP_W-1:0] STEP_MUL_PHASE = 4'd3;
    localparam logic [STEP_W-1:0] STEP_MUL_SQ    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_LOOP      = 4'd5;
    localparam logic [STEP_W-1:0] STEP_FIRST     = 4'd6;
    localparam logic [STEP_W-1:0] STEP_MUL_TERM  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_DIV_TERM  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_ACC       = 4'd9;
    localparam logic [STEP_W-1:0] STEP_EMIT      = 4'd10;
    localparam logic [STEP_W-1:0] STEP_EMIT_OOR  = 4'd11;

    // control store
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{op: UOP_WAIT_IN, unit: U_NONE, wait_on: W_INPUT, cond: C_NEXT, target: STEP_IDLE};
        unique case (step)
            STEP_IDLE:      w = '{op: UOP_WAIT_IN, unit: U_NONE, wait_on: W_INPUT,
                                  cond: C_NEXT, target: STEP_IDLE};
            STEP_CHECK:     w = '{op: UOP_CHECK, unit: U_NONE, wait_on: W_NONE,
                                  cond: C_IF_OOR, target: STEP_EMIT_OOR};
            STEP_DIV_PHASE: w = '{op: UOP_DIV_PHASE, unit: U_DIV, wait_on: W_UNIT,
                                  cond: C_NEXT, target: STEP_IDLE};
            STEP_MUL_PHASE: w = '{op: UOP_MUL_PHASE, unit: U_MUL, wait_on: W_UNIT,
                                  cond: C_NEXT, target: STEP_IDLE};
            STEP_MUL_SQ:    w = '{op: UOP_MUL_SQ, unit: U_MUL, wait_on: W_UNIT,
                                  cond: C_NEXT, target: STEP_IDLE};
            STEP_LOOP:      w = '{op: UOP_LOOP_TEST, unit: U_NONE, wait_on: W_NONE,
                                  cond: C_IF_LOOP_END, target: STEP_EMIT};
            STEP_FIRST:     w = '{op: UOP_FIRST_TEST, unit: U_NONE, wait_on: W_NONE,
                                  cond: C_IF_FIRST, target: STEP_ACC};
            STEP_MUL_TERM:  w = '{op: UOP_MUL_TERM, unit: U_MUL, wait_on: W_UNIT,
                                  cond: C_NEXT, target: STEP_IDLE};
            STEP_DIV_TERM:  w = '{op: UOP_DIV_TERM, unit: U_DIV, wait_on: W_UNIT,
                                  cond: C_NEXT, target: STEP_IDLE};
            STEP_ACC:       w = '{op: UOP_ACCUM, unit: U_NONE, wait_on: W_NONE,
                                  cond: C_JUMP, target: STEP_LOOP};
            STEP_EMIT:      w = '{op: UOP_EMIT, unit: U_NONE, wait_on: W_OUTPUT,
                                  cond: C_JUMP, target: STEP_IDLE};
            STEP_EMIT_OOR:  w = '{op: UOP_EMIT_OOR, unit: U_NONE, wait_on: W_OUTPUT,
                                  cond: C_JUMP, target: STEP_IDLE};
            default:        w = '{op: UOP_WAIT_IN, unit: U_NONE, wait_on: W_INPUT,
                                  cond: C_NEXT, target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/tse_mul.sv]
// tse_mul: iterative 48x48 unsigned multiplier, one 16-bit digit of b per cycle
// depends on tse_pkg
`default_nettype none

module tse_mul (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_go,
    input  wire logic [tse_pkg::WIDE_W-1:0]   i_a,
    input  wire logic [tse_pkg::WIDE_W-1:0]   i_b,
    output logic                              o_done,
    output logic      [tse_pkg::PROD_W-1:0]   o_prod
);

    localparam int CNT_W = (tse_pkg::MUL_CYCLES > 1) ? $clog2(tse_pkg::MUL_CYCLES) : 1;
    localparam int PP_W  = tse_pkg::WIDE_W + tse_pkg::DIGIT_W;

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [tse_pkg::WIDE_W-1:0]    r_a;
    logic [tse_pkg::WIDE_W-1:0]    r_b;
    logic [tse_pkg::PROD_W-1:0]    r_acc;
    logic [PP_W-1:0]               w_pp;
    logic                          w_last;

    assign w_pp   = r_a * r_b[tse_pkg::WIDE_W-1 -: tse_pkg::DIGIT_W];
    assign w_last = (r_cnt == CNT_W'(tse_pkg::MUL_CYCLES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // msb digit first
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_b   <= r_b << tse_pkg::DIGIT_W;
            r_acc <= (r_acc << tse_pkg::DIGIT_W) + tse_pkg::PROD_W'(w_pp);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

[rtl/tse_div.sv]
// tse_div: iterative restoring divider, 48-bit dividend by 16-bit divisor, 4 bits per cycle
// depends on tse_pkg
`default_nettype none

module tse_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_go,
    input  wire logic [tse_pkg::WIDE_W-1:0]   i_dividend,
    input  wire logic [tse_pkg::DIV_W-1:0]    i_divisor,
    output logic                              o_done,
    output logic      [tse_pkg::WIDE_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(tse_pkg::DIV_CYCLES);
    localparam int REM_W = tse_pkg::DIV_W + 1;

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [tse_pkg::DIV_W-1:0]     r_divisor;
    logic [REM_W-1:0]              r_rem;
    logic [tse_pkg::WIDE_W-1:0]    r_quo;
    logic [REM_W-1:0]              n_rem;
    logic [tse_pkg::WIDE_W-1:0]    n_quo;
    logic                          w_last;

    assign w_last = (r_cnt == CNT_W'(tse_pkg::DIV_CYCLES - 1));

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < tse_pkg::DIV_RADIX; k++) begin
            n_rem = {n_rem[REM_W-2:0], n_quo[tse_pkg::WIDE_W-1]};
            n_quo = {n_quo[tse_pkg::WIDE_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_divisor}) begin
                n_rem    = n_rem - {1'b0, r_divisor};
                n_quo[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_divisor <= i_divisor;
            r_rem     <= '0;
            r_quo     <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

[rtl/tse_seq.sv]
// tse_seq: microcode sequencer, step counter over the control store with conditional jumps
// depends on tse_pkg (ucode, t_ctrl, t_flags)
`default_nettype none

module tse_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tse_pkg::t_flags   i_flags,
    output tse_pkg::t_ctrl         o_ctrl
);

    logic [tse_pkg::STEP_W-1:0] r_pc;
    logic [tse_pkg::STEP_W-1:0] n_pc;
    logic                       r_issued;
    logic                       n_issued;
    tse_pkg::t_uword            w_uw;
    logic                       w_advance;
    logic                       w_taken;
    logic                       w_go;

    assign w_uw = tse_pkg::ucode(r_pc);
    assign w_go = (w_uw.unit != tse_pkg::U_NONE) && !r_issued;

    always_comb begin
        unique case (w_uw.wait_on)
            tse_pkg::W_NONE:   w_advance = 1'b1;
            tse_pkg::W_INPUT:  w_advance = i_flags.accept;
            tse_pkg::W_UNIT:   w_advance = r_issued && i_flags.unit_done;
            tse_pkg::W_OUTPUT: w_advance = i_flags.out_free;
            default:           w_advance = 1'b0;
        endcase
    end

    always_comb begin
        unique case (w_uw.cond)
            tse_pkg::C_NEXT:        w_taken = 1'b0;
            tse_pkg::C_JUMP:        w_taken = 1'b1;
            tse_pkg::C_IF_OOR:      w_taken = i_flags.oor;
            tse_pkg::C_IF_LOOP_END: w_taken = i_flags.loop_end;
            tse_pkg::C_IF_FIRST:    w_taken = i_flags.first;
            default:                w_taken = 1'b0;
        endcase
    end

    always_comb begin
        n_pc     = r_pc;
        n_issued = r_issued | w_go;
        if (w_advance) begin
            n_pc     = w_taken ? w_uw.target : r_pc + tse_pkg::STEP_W'(1);
            n_issued = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= tse_pkg::STEP_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_pc     <= n_pc;
            r_issued <= n_issued;
        end
    end

    assign o_ctrl.op      = w_uw.op;
    assign o_ctrl.advance = w_advance;
    assign o_ctrl.mul_go  = w_go && (w_uw.unit == tse_pkg::U_MUL);
    assign o_ctrl.div_go  = w_go && (w_uw.unit == tse_pkg::U_DIV);

endmodule

`default_nettype wire

[rtl/taylor_sine_evaluator.sv]
// one request at a time; the next is accepted after the result is registered. each term after
// the first takes a multiply and a divide (4 bits/cycle)
// reset (synchronous, active low): readies low, sequencer idle, output empty, count 8, div 64
// top level: datapath, config registers, output register; depends on tse_pkg, tse_seq,
// tse_mul, tse_div
`default_nettype none

module taylor_sine_evaluator #(
    parameter int MAX_TERMS = tse_pkg::MAX_TERMS_DEF,
    parameter int FRAC_BITS = tse_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic        [tse_pkg::IDX_W-1:0]  i_sample_index,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed      [tse_pkg::SINE_W-1:0] o_sine_value,
    output logic                                   o_out_of_range,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic    [tse_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic    [tse_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int JW       = (MAX_TERMS > 1) ? $clog2(MAX_TERMS + 1) : 1;
    localparam int PW1      = tse_pkg::PROD_W + 1;
    localparam int SH_PHASE = 61 - FRAC_BITS;
    localparam logic [PW1-1:0] RND_PHASE = PW1'(1) << (SH_PHASE - 1);
    localparam logic [PW1-1:0] RND_FRAC  = PW1'(1) << (FRAC_BITS - 1);
    localparam int SH_DN   = (FRAC_BITS > tse_pkg::OUT_FRAC) ? FRAC_BITS - tse_pkg::OUT_FRAC : 0;
    localparam int SH_UP   = (FRAC_BITS < tse_pkg::OUT_FRAC) ? tse_pkg::OUT_FRAC - FRAC_BITS : 0;
    localparam int RND_POS = (FRAC_BITS > tse_pkg::OUT_FRAC) ? SH_DN - 1 : 0;
    localparam logic [63:0] RND_DN = (FRAC_BITS > tse_pkg::OUT_FRAC) ? (64'd1 << RND_POS) : 64'd0;
    localparam logic [5:0]  MAX6   = 6'(MAX_TERMS);

    tse_pkg::t_ctrl  w_ctrl;
    tse_pkg::t_flags w_flags;

    // config
    logic [tse_pkg::TC_W-1:0]   r_term_count;
    logic [tse_pkg::DIV_W-1:0]  r_period_divisor;

    // datapath
    logic [tse_pkg::IDX_W-1:0]   r_idx;
    logic [JW-1:0]               r_count;
    logic [JW-1:0]               r_j;
    logic [tse_pkg::QUOT_W-1:0]  r_quot;
    logic [tse_pkg::PHASE_W-1:0] r_phase;
    logic [tse_pkg::WIDE_W-1:0]  r_phase_sq;
    logic [tse_pkg::WIDE_W-1:0]  r_term;
    logic [tse_pkg::WIDE_W-1:0]  r_sum;

    // output register
    logic                        r_out_valid;
    logic [tse_pkg::SINE_W-1:0]  r_sine;
    logic                        r_oor;

    logic                        w_accept;
    logic [5:0]                  w_tc6;
    logic [5:0]                  w_cnt6;
    logic [6:0]                  w_j2;
    logic [13:0]                 w_d14;
    logic [tse_pkg::DIV_W-1:0]   w_term_div;
    logic [tse_pkg::WIDE_W-1:0]  w_mul_a;
    logic [tse_pkg::WIDE_W-1:0]  w_mul_b;
    logic [tse_pkg::WIDE_W-1:0]  w_dividend;
    logic [tse_pkg::DIV_W-1:0]   w_divisor;
    logic                        w_mul_done;
    logic [tse_pkg::PROD_W-1:0]  w_prod;
    logic                        w_div_done;
    logic [tse_pkg::WIDE_W-1:0]  w_quo;
    logic [PW1-1:0]              w_rnd_phase;
    logic [PW1-1:0]              w_rnd_frac;
    logic [tse_pkg::WIDE_W-1:0]  w_mag48;
    logic [63:0]                 w_mag;
    logic [tse_pkg::SINE_W-1:0]  w_sat;

    assign o_in_ready = i_rst_n && (w_ctrl.op == tse_pkg::UOP_WAIT_IN);
    assign o_cfg_ready = i_rst_n;
    assign w_accept = i_in_valid && o_in_ready;

    assign w_flags.accept    = w_accept;
    assign w_flags.unit_done = w_mul_done || w_div_done;
    assign w_flags.out_free  = !r_out_valid || i_out_ready;
    assign w_flags.oor       = (r_idx >= r_period_divisor);
    assign w_flags.loop_end  = (r_j == r_count);
    assign w_flags.first     = (r_j == '0);

    tse_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    // term count saturated to MAX_TERMS
    assign w_tc6  = 6'(r_term_count);
    assign w_cnt6 = (w_tc6 > MAX6) ? MAX6 : w_tc6;

    // divisor (2j)(2j+1) of term j
    assign w_j2       = {6'(r_j), 1'b0};
    assign w_d14      = 14'(w_j2) * 14'(w_j2 + 7'd1);
    assign w_term_div = tse_pkg::DIV_W'(w_d14);

    always_comb begin
        case (w_ctrl.op)
            tse_pkg::UOP_MUL_PHASE: begin
                w_mul_a = tse_pkg::WIDE_W'(r_quot);
                w_mul_b = tse_pkg::WIDE_W'(tse_pkg::TWO_PI_Q29);
            end
            tse_pkg::UOP_MUL_SQ: begin
                w_mul_a = tse_pkg::WIDE_W'(r_phase);
                w_mul_b = tse_pkg::WIDE_W'(r_phase);
            end
            default: begin
                w_mul_a = r_term;
                w_mul_b = r_phase_sq;
            end
        endcase
    end

    always_comb begin
        case (w_ctrl.op)
            tse_pkg::UOP_DIV_PHASE: begin
                w_dividend = {r_idx, {tse_pkg::QUOT_W{1'b0}}}
                           + tse_pkg::WIDE_W'(r_period_divisor >> 1);
                w_divisor  = r_period_divisor;
            end
            default: begin
                w_dividend = r_term + tse_pkg::WIDE_W'(w_term_div >> 1);
                w_divisor  = w_term_div;
            end
        endcase
    end

    tse_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_ctrl.mul_go),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    tse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (w_ctrl.div_go),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quo)
    );

    // round to nearest on product writeback
    assign w_rnd_phase = ({1'b0, w_prod} + RND_PHASE) >> SH_PHASE;
    assign w_rnd_frac  = ({1'b0, w_prod} + RND_FRAC) >> FRAC_BITS;

    // sum to q8.24 with saturation
    always_comb begin
        w_mag48 = r_sum[tse_pkg::WIDE_W-1] ? (tse_pkg::WIDE_W'(0) - r_sum) : r_sum;
        w_mag   = ((64'(w_mag48) + RND_DN) >> SH_DN) << SH_UP;
        if (r_sum[tse_pkg::WIDE_W-1]) begin
            w_sat = (w_mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - w_mag);
        end else begin
            w_sat = (w_mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : w_mag[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count     <= tse_pkg::TERM_COUNT_RST;
            r_period_divisor <= tse_pkg::PERIOD_DIV_RST;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    tse_pkg::REG_TERM_COUNT:     r_term_count <= i_cfg_data[tse_pkg::TC_W-1:0];
                    tse_pkg::REG_PERIOD_DIVISOR: r_period_divisor <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_ctrl.advance && (w_ctrl.op == tse_pkg::UOP_EMIT
                                   || w_ctrl.op == tse_pkg::UOP_EMIT_OOR)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.advance) begin
            unique case (w_ctrl.op)
                tse_pkg::UOP_WAIT_IN: begin
                    r_idx   <= i_sample_index;
                    r_count <= w_cnt6[JW-1:0];
                end
                tse_pkg::UOP_DIV_PHASE: begin
                    r_quot <= w_quo[tse_pkg::QUOT_W-1:0];
                end
                tse_pkg::UOP_MUL_PHASE: begin
                    r_phase <= w_rnd_phase[tse_pkg::PHASE_W-1:0];
                end
                tse_pkg::UOP_MUL_SQ: begin
                    r_phase_sq <= w_rnd_frac[tse_pkg::WIDE_W-1:0];
                    r_term     <= tse_pkg::WIDE_W'(r_phase);
                    r_sum      <= '0;
                    r_j        <= '0;
                end
                tse_pkg::UOP_MUL_TERM: begin
                    r_term <= w_rnd_frac[tse_pkg::WIDE_W-1:0];
                end
                tse_pkg::UOP_DIV_TERM: begin
                    r_term <= w_quo;
                end
                tse_pkg::UOP_ACCUM: begin
                    r_sum <= r_j[0] ? (r_sum - r_term) : (r_sum + r_term);
                    r_j   <= r_j + JW'(1);
                end
                tse_pkg::UOP_EMIT: begin
                    r_sine <= w_sat;
                    r_oor  <= 1'b0;
                end
                tse_pkg::UOP_EMIT_OOR: begin
                    r_sine <= '0;
                    r_oor  <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sine_value   = r_sine;
    assign o_out_of_range = r_oor;

endmodule

`default_nettype wire

[rtl/tse_checker.sv]
// tse_checker: port-level assertions for taylor_sine_evaluator, attached by bind
// depends on tse_pkg and the top level port list
`default_nettype none

module tse_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_in_valid,
    input wire logic                               o_in_ready,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_ready,
    input wire logic signed [tse_pkg::SINE_W-1:0]  o_sine_value,
    input wire logic                               o_out_of_range
);

    // out-of-range result carries zero
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_of_range |-> o_sine_value == '0)
        else $error("out-of-range result with nonzero value");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_sine_value) && $stable(o_out_of_range))
        else $error("result changed while stalled");

    // one request in flight
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while previous in flight");

    // a new result is only produced while busy
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result produced while idle");

endmodule

bind taylor_sine_evaluator tse_checker u_tse_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_sine_value   (o_sine_value),
    .o_out_of_range (o_out_of_range)
);

`default_nettype wire
